>>> rtl/stac_pkg.sv
// Shared codes, widths and reset values for the sensor threshold actuator control unit.
package stac_pkg;

    localparam int TEMP_W  = 8;
    localparam int HUM_W   = 7;
    localparam int ADC_W   = 12;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 3;
    localparam int PROD_W  = TEMP_W + ADC_W;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CIDX_W-1:0] t_cfg_idx;

    localparam t_action ACT_POLL    = 3'd0;
    localparam t_action ACT_SELECT  = 3'd1;
    localparam t_action ACT_RLY_ON  = 3'd2;
    localparam t_action ACT_RLY_OFF = 3'd3;
    localparam t_action ACT_AUTO    = 3'd4;
    localparam t_action ACT_FAN_MAX = 3'd5;
    localparam t_action ACT_FAN_OFF = 3'd6;

    localparam t_status ST_NORMAL   = 2'd0;
    localparam t_status ST_WARNING  = 2'd1;
    localparam t_status ST_ALARM    = 2'd2;
    localparam t_status ST_OVERRIDE = 2'd3;

    localparam t_cfg_idx CFG_TEMP_WARN  = 3'd0;
    localparam t_cfg_idx CFG_TEMP_HIGH  = 3'd1;
    localparam t_cfg_idx CFG_TEMP_CRIT  = 3'd2;
    localparam t_cfg_idx CFG_HUM_HIGH   = 3'd3;
    localparam t_cfg_idx CFG_GAS_WARN   = 3'd4;
    localparam t_cfg_idx CFG_GAS_ALARM  = 3'd5;
    localparam t_cfg_idx CFG_LIGHT_DARK = 3'd6;
    localparam t_cfg_idx CFG_FAN_PERIOD = 3'd7;

    localparam logic [TEMP_W-1:0] RST_TEMP_WARN  = 8'd30;
    localparam logic [TEMP_W-1:0] RST_TEMP_HIGH  = 8'd35;
    localparam logic [TEMP_W-1:0] RST_TEMP_CRIT  = 8'd45;
    localparam logic [HUM_W-1:0]  RST_HUM_HIGH   = 7'd80;
    localparam logic [ADC_W-1:0]  RST_GAS_WARN   = 12'd1500;
    localparam logic [ADC_W-1:0]  RST_GAS_ALARM  = 12'd2500;
    localparam logic [ADC_W-1:0]  RST_LIGHT_DARK = 12'd1000;
    localparam logic [ADC_W-1:0]  RST_FAN_PERIOD = 12'd999;

endpackage

>>> rtl/sensor_threshold_actuator_control_unit.sv
// Top level of the sensor threshold actuator control unit with a bit-serial fan ramp unit.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   input    | i_valid / o_ready          | i_action, i_temperature, i_humidity, ...
//   output   | o_valid / i_ready          | o_fan_pwm, o_relay_out, o_buzzer_out, ...
//   config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// An event that needs no fan ramp goes from acceptance straight to the done state, where
// its result is loaded into the output register once that is free. A poll on the fan ramp
// first runs 8 shift-add multiply steps, one per bit of the temperature offset, and 20
// restoring division steps, one per product bit, before it reaches the done state.
// Reset is synchronous and active low; it resets state, config, actuators and o_valid only.
// One event is in work at a time; a result waiting in the output register holds the current
// event in its last cycle, which keeps o_ready low until the result is taken.
module sensor_threshold_actuator_control_unit
    import stac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [ADC_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_action           i_action,
    input  logic [TEMP_W-1:0] i_temperature,
    input  logic [HUM_W-1:0]  i_humidity,
    input  logic              i_climate_valid,
    input  logic [ADC_W-1:0]  i_gas_level,
    input  logic [ADC_W-1:0]  i_light_level,
    input  logic              i_motion,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADC_W-1:0]  o_fan_pwm,
    output logic              o_relay_out,
    output logic              o_buzzer_out,
    output logic              o_override_active,
    output t_status           o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int CNT_W = $clog2(PROD_W + 1);
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(TEMP_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);

    logic [TEMP_W-1:0] r_temp_warn, r_temp_high, r_temp_crit;
    logic [HUM_W-1:0]  r_hum_high;
    logic [ADC_W-1:0]  r_gas_warn, r_gas_alarm, r_light_dark, r_fan_period;

    logic              r_relay, r_override, r_buzzer;
    logic [ADC_W-1:0]  r_fan;
    t_status           r_status;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_mcand;
    logic [TEMP_W-1:0] r_mplier;
    logic [PROD_W-1:0] r_prod;
    logic [TEMP_W-1:0] r_rem;
    logic [TEMP_W-1:0] r_divisor;

    logic              r_out_valid;
    logic [ADC_W-1:0]  r_out_fan;
    logic              r_out_relay, r_out_buzzer, r_out_override;
    t_status           r_out_status;

    logic              accept;
    logic              g_alarm, g_warn, crit, dark, t_high, h_high, ramp;
    logic [TEMP_W:0]   rem_sh;
    logic              rem_ge;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    assign g_alarm = (i_gas_level >= r_gas_alarm);
    assign g_warn  = (i_gas_level >= r_gas_warn);
    assign crit    = i_climate_valid && (i_temperature >= r_temp_crit);
    assign dark    = (i_light_level < r_light_dark);
    assign t_high  = (i_temperature >= r_temp_high);
    assign h_high  = (i_humidity >= r_hum_high);
    assign ramp    = !g_alarm && i_climate_valid && (i_temperature >= r_temp_warn) && !t_high;

    assign rem_sh  = {r_rem, r_prod[PROD_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_warn  <= RST_TEMP_WARN;
            r_temp_high  <= RST_TEMP_HIGH;
            r_temp_crit  <= RST_TEMP_CRIT;
            r_hum_high   <= RST_HUM_HIGH;
            r_gas_warn   <= RST_GAS_WARN;
            r_gas_alarm  <= RST_GAS_ALARM;
            r_light_dark <= RST_LIGHT_DARK;
            r_fan_period <= RST_FAN_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP_WARN:  r_temp_warn  <= i_cfg_data[TEMP_W-1:0];
                CFG_TEMP_HIGH:  r_temp_high  <= i_cfg_data[TEMP_W-1:0];
                CFG_TEMP_CRIT:  r_temp_crit  <= i_cfg_data[TEMP_W-1:0];
                CFG_HUM_HIGH:   r_hum_high   <= i_cfg_data[HUM_W-1:0];
                CFG_GAS_WARN:   r_gas_warn   <= i_cfg_data;
                CFG_GAS_ALARM:  r_gas_alarm  <= i_cfg_data;
                CFG_LIGHT_DARK: r_light_dark <= i_cfg_data;
                CFG_FAN_PERIOD: r_fan_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_relay     <= 1'b0;
            r_override  <= 1'b0;
            r_buzzer    <= 1'b0;
            r_fan       <= '0;
            r_status    <= ST_NORMAL;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (i_action == ACT_POLL && ramp) ? S_MUL : S_DONE;
                        unique case (i_action)
                            ACT_POLL: begin
                                if (g_alarm) begin
                                    r_fan <= r_fan_period;
                                end else if (i_climate_valid && t_high
                                             && (i_temperature >= r_temp_warn)) begin
                                    r_fan <= r_fan_period;
                                end else if (!ramp) begin
                                    r_fan <= '0;
                                end
                                if (ramp) begin
                                    r_cnt    <= MUL_STEPS;
                                    r_mcand  <= PROD_W'(r_fan_period);
                                    r_mplier <= i_temperature - r_temp_warn;
                                    r_prod   <= '0;
                                    r_divisor <= r_temp_high - r_temp_warn;
                                end
                                if (!r_override) begin
                                    priority if (g_alarm || crit) begin
                                        r_relay <= 1'b0;
                                    end else if (dark && i_motion) begin
                                        r_relay <= 1'b1;
                                    end else if (!dark) begin
                                        r_relay <= 1'b0;
                                    end else begin
                                        r_relay <= r_relay;
                                    end
                                end
                                priority if (g_alarm) begin
                                    r_buzzer <= 1'b1;
                                end else if (g_warn || crit) begin
                                    r_buzzer <= !r_buzzer;
                                end else begin
                                    r_buzzer <= 1'b0;
                                end
                                priority if (g_alarm || crit) begin
                                    r_status <= ST_ALARM;
                                end else if (g_warn || (i_climate_valid && (t_high || h_high))) begin
                                    r_status <= ST_WARNING;
                                end else if (r_override) begin
                                    r_status <= ST_OVERRIDE;
                                end else begin
                                    r_status <= ST_NORMAL;
                                end
                            end
                            ACT_SELECT: begin
                                priority if (!r_override) begin
                                    r_override <= 1'b1;
                                    r_relay    <= 1'b1;
                                end else if (r_relay) begin
                                    r_relay    <= 1'b0;
                                end else begin
                                    r_override <= 1'b0;
                                end
                            end
                            ACT_RLY_ON: begin
                                r_override <= 1'b1;
                                r_relay    <= 1'b1;
                            end
                            ACT_RLY_OFF: begin
                                r_override <= 1'b1;
                                r_relay    <= 1'b0;
                            end
                            ACT_AUTO:    r_override <= 1'b0;
                            ACT_FAN_MAX: r_fan      <= r_fan_period;
                            ACT_FAN_OFF: r_fan      <= '0;
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_prod <= r_prod + r_mcand;
                    end
                    r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[TEMP_W-1:1]};
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DIV;
                        r_cnt   <= DIV_STEPS;
                        r_rem   <= '0;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? TEMP_W'(rem_sh - {1'b0, r_divisor}) : rem_sh[TEMP_W-1:0];
                    r_prod <= {r_prod[PROD_W-2:0], rem_ge};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DONE;
                        r_fan   <= {r_prod[ADC_W-2:0], rem_ge};
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
            r_out_fan      <= r_fan;
            r_out_relay    <= r_relay;
            r_out_buzzer   <= r_buzzer;
            r_out_override <= r_override;
            r_out_status   <= r_status;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_fan_pwm         = r_out_fan;
    assign o_relay_out       = r_out_relay;
    assign o_buzzer_out      = r_out_buzzer;
    assign o_override_active = r_out_override;
    assign o_status          = r_out_status;

endmodule

>>> sim/tb_sensor_threshold_actuator_control_unit.sv
// Self-checking testbench for the sensor threshold actuator control unit.
module tb_sensor_threshold_actuator_control_unit;
    import stac_pkg::*;

    localparam t_action ACT_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_EVENTS = 210;

    typedef struct {
        t_action            action;
        logic [TEMP_W-1:0]  temp;
        logic [HUM_W-1:0]   hum;
        logic               climate_ok;
        logic [ADC_W-1:0]   gas;
        logic [ADC_W-1:0]   light;
        logic               motion;
    } t_sensor_event;

    typedef struct packed {
        logic [ADC_W-1:0] fan_pwm;
        logic             relay;
        logic             buzzer;
        logic             override_on;
        t_status          status;
    } t_actuators;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    t_cfg_idx          i_cfg_idx = CFG_TEMP_WARN;
    logic [ADC_W-1:0]  i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    t_action           i_action = ACT_POLL;
    logic [TEMP_W-1:0] i_temperature = '0;
    logic [HUM_W-1:0]  i_humidity = '0;
    logic              i_climate_valid = 1'b0;
    logic [ADC_W-1:0]  i_gas_level = '0;
    logic [ADC_W-1:0]  i_light_level = '0;
    logic              i_motion = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [ADC_W-1:0]  o_fan_pwm;
    logic              o_relay_out;
    logic              o_buzzer_out;
    logic              o_override_active;
    t_status           o_status;

    sensor_threshold_actuator_control_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_action          (i_action),
        .i_temperature     (i_temperature),
        .i_humidity        (i_humidity),
        .i_climate_valid   (i_climate_valid),
        .i_gas_level       (i_gas_level),
        .i_light_level     (i_light_level),
        .i_motion          (i_motion),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_fan_pwm         (o_fan_pwm),
        .o_relay_out       (o_relay_out),
        .o_buzzer_out      (o_buzzer_out),
        .o_override_active (o_override_active),
        .o_status          (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [ADC_W-1:0] thr [8];
    logic [ADC_W-1:0] duty_now;
    logic             relay_now;
    logic             manual_mode;
    logic             buzzing;
    t_status          status_now;

    t_actuators actuator_q [$];
    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  no_gaps = 1'b0;

    function automatic void reset_model();
        thr[CFG_TEMP_WARN]  = ADC_W'(RST_TEMP_WARN);
        thr[CFG_TEMP_HIGH]  = ADC_W'(RST_TEMP_HIGH);
        thr[CFG_TEMP_CRIT]  = ADC_W'(RST_TEMP_CRIT);
        thr[CFG_HUM_HIGH]   = ADC_W'(RST_HUM_HIGH);
        thr[CFG_GAS_WARN]   = RST_GAS_WARN;
        thr[CFG_GAS_ALARM]  = RST_GAS_ALARM;
        thr[CFG_LIGHT_DARK] = RST_LIGHT_DARK;
        thr[CFG_FAN_PERIOD] = RST_FAN_PERIOD;
        duty_now    = '0;
        relay_now   = 1'b0;
        manual_mode = 1'b0;
        buzzing     = 1'b0;
        status_now  = ST_NORMAL;
    endfunction

    function automatic t_actuators step_controller(t_sensor_event ev);
        logic [TEMP_W-1:0] warn, high, crit;
        logic [HUM_W-1:0]  hum_hi;
        logic [ADC_W-1:0]  period;
        logic [TEMP_W-1:0] offset;
        logic [PROD_W-1:0] prod, quot;
        logic              g_alarm, g_warn, crit_hit, dark;
        t_actuators        r;
        warn   = thr[CFG_TEMP_WARN][TEMP_W-1:0];
        high   = thr[CFG_TEMP_HIGH][TEMP_W-1:0];
        crit   = thr[CFG_TEMP_CRIT][TEMP_W-1:0];
        hum_hi = thr[CFG_HUM_HIGH][HUM_W-1:0];
        period = thr[CFG_FAN_PERIOD];
        case (ev.action)
            ACT_POLL: begin
                g_alarm  = ev.gas >= thr[CFG_GAS_ALARM];
                g_warn   = ev.gas >= thr[CFG_GAS_WARN];
                crit_hit = ev.climate_ok && ev.temp >= crit;
                dark     = ev.light < thr[CFG_LIGHT_DARK];
                if (g_alarm) begin
                    duty_now = period;
                end else if (ev.climate_ok) begin
                    if (ev.temp < warn) begin
                        duty_now = '0;
                    end else if (ev.temp >= high) begin
                        duty_now = period;
                    end else begin
                        offset   = ev.temp - warn;
                        prod     = PROD_W'(offset) * PROD_W'(period);
                        quot     = prod / PROD_W'(high - warn);
                        duty_now = (quot > PROD_W'(period)) ? period : quot[ADC_W-1:0];
                    end
                end else begin
                    duty_now = '0;
                end
                if (!manual_mode) begin
                    if (g_alarm || crit_hit) begin
                        relay_now = 1'b0;
                    end else if (dark && ev.motion) begin
                        relay_now = 1'b1;
                    end else if (!dark) begin
                        relay_now = 1'b0;
                    end
                end
                if (g_alarm) begin
                    buzzing = 1'b1;
                end else if (g_warn || crit_hit) begin
                    buzzing = !buzzing;
                end else begin
                    buzzing = 1'b0;
                end
                if (g_alarm || crit_hit) begin
                    status_now = ST_ALARM;
                end else if (g_warn || (ev.climate_ok && (ev.temp >= high || ev.hum >= hum_hi))) begin
                    status_now = ST_WARNING;
                end else if (manual_mode) begin
                    status_now = ST_OVERRIDE;
                end else begin
                    status_now = ST_NORMAL;
                end
            end
            ACT_SELECT: begin
                if (!manual_mode) begin
                    manual_mode = 1'b1;
                    relay_now   = 1'b1;
                end else if (relay_now) begin
                    relay_now = 1'b0;
                end else begin
                    manual_mode = 1'b0;
                end
            end
            ACT_RLY_ON: begin
                manual_mode = 1'b1;
                relay_now   = 1'b1;
            end
            ACT_RLY_OFF: begin
                manual_mode = 1'b1;
                relay_now   = 1'b0;
            end
            ACT_AUTO:    manual_mode = 1'b0;
            ACT_FAN_MAX: duty_now = period;
            ACT_FAN_OFF: duty_now = '0;
            default: ;
        endcase
        r.fan_pwm     = duty_now;
        r.relay       = relay_now;
        r.buzzer      = buzzing;
        r.override_on = manual_mode;
        r.status      = status_now;
        return r;
    endfunction

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic t_sensor_event random_event();
        t_sensor_event ev;
        if ($urandom_range(99) < 55) begin
            ev.action = ACT_POLL;
        end else begin
            ev.action = t_action'($urandom_range(1, 7));
        end
        if ($urandom_range(3) == 0) begin
            ev.temp = TEMP_W'($urandom_range(255));
        end else begin
            ev.temp = TEMP_W'(clip(int'(thr[CFG_TEMP_WARN]) + int'($urandom_range(30)) - 8,
                                   255));
        end
        ev.hum        = HUM_W'($urandom_range(127));
        ev.climate_ok = ($urandom_range(9) != 0);
        if ($urandom_range(2) == 0) begin
            ev.gas = ADC_W'($urandom_range(4095));
        end else begin
            ev.gas = ADC_W'(clip(int'(thr[CFG_GAS_WARN]) + int'($urandom_range(1600)) - 400,
                                 4095));
        end
        if ($urandom_range(1) == 0) begin
            ev.light = ADC_W'($urandom_range(4095));
        end else begin
            ev.light = ADC_W'(clip(int'(thr[CFG_LIGHT_DARK]) + int'($urandom_range(600)) - 300,
                                   4095));
        end
        ev.motion = 1'($urandom_range(1));
        return ev;
    endfunction

    function automatic t_sensor_event poll_event(int t, int h, bit ok, int gas, int light,
                                                 bit mv);
        t_sensor_event ev;
        ev.action     = ACT_POLL;
        ev.temp       = TEMP_W'(t);
        ev.hum        = HUM_W'(h);
        ev.climate_ok = ok;
        ev.gas        = ADC_W'(gas);
        ev.light      = ADC_W'(light);
        ev.motion     = mv;
        return ev;
    endfunction

    function automatic t_sensor_event cmd_event(t_action a);
        t_sensor_event ev;
        ev = random_event();
        ev.action = a;
        return ev;
    endfunction

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", what);
        end
    endtask

    task automatic send_event(input t_sensor_event ev);
        if (!no_gaps && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= ev.action;
        i_temperature   <= ev.temp;
        i_humidity      <= ev.hum;
        i_climate_valid <= ev.climate_ok;
        i_gas_level     <= ev.gas;
        i_light_level   <= ev.light;
        i_motion        <= ev.motion;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        actuator_q.push_back(step_controller(ev));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (actuator_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_register(input t_cfg_idx idx, input logic [ADC_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_TEMP_WARN, CFG_TEMP_HIGH, CFG_TEMP_CRIT: thr[idx] = data & 12'h0FF;
            CFG_HUM_HIGH: thr[idx] = data & 12'h07F;
            default: thr[idx] = data;
        endcase
    endtask

    task automatic randomize_thresholds(input bit raw);
        int v [8];
        if (raw) begin
            foreach (v[i]) v[i] = $urandom_range(4095);
        end else begin
            v[CFG_TEMP_WARN] = $urandom_range(80);
            v[CFG_TEMP_HIGH] = ($urandom_range(4) == 0) ? $urandom_range(v[CFG_TEMP_WARN])
                                                        : v[CFG_TEMP_WARN] + $urandom_range(1, 40);
            v[CFG_TEMP_CRIT] = clip(v[CFG_TEMP_HIGH] + $urandom_range(30), 255);
            v[CFG_HUM_HIGH]  = $urandom_range(30, 127);
            v[CFG_GAS_WARN]  = $urandom_range(200, 3000);
            v[CFG_GAS_ALARM] = clip(v[CFG_GAS_WARN] + $urandom_range(1500), 4095);
            v[CFG_LIGHT_DARK] = $urandom_range(4095);
            v[CFG_FAN_PERIOD] = $urandom_range(1, 4095);
        end
        foreach (v[i]) program_register(t_cfg_idx'(i), ADC_W'(v[i]));
    endtask

    always @(posedge i_clk) begin
        i_ready <= no_gaps || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("no transaction for %0d cycles", QUIET_LIMIT);
        $display("tb_sensor_threshold_actuator_control_unit: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin : check_outputs
        t_actuators got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_fan_pwm, o_relay_out, o_buzzer_out, o_override_active, o_status};
            if (actuator_q.size() == 0) begin
                log_failure($sformatf("unexpected transaction: duty=%0d relay=%0b buzzer=%0b override=%0b status=%0d",
                                      got.fan_pwm, got.relay, got.buzzer, got.override_on,
                                      got.status));
            end else begin
                want = actuator_q.pop_front();
                if (got != want) begin
                    log_failure($sformatf({"mismatch: expected duty=%0d relay=%0b buzzer=%0b ",
                                           "override=%0b status=%0d, got duty=%0d relay=%0b ",
                                           "buzzer=%0b override=%0b status=%0d"},
                                          want.fan_pwm, want.relay, want.buzzer,
                                          want.override_on, want.status, got.fan_pwm,
                                          got.relay, got.buzzer, got.override_on, got.status));
                end
            end
        end
    end

    task automatic test_reset_state();
        send_event(cmd_event(ACT_UNUSED));
        send_event(poll_event(20, 40, 1'b1, 100, 3000, 1'b0));
    endtask

    task automatic test_fan_ramp();
        send_event(poll_event(29, 40, 1'b1, 0, 3000, 1'b0));
        send_event(poll_event(30, 40, 1'b1, 0, 3000, 1'b0));
        send_event(poll_event(32, 40, 1'b1, 0, 3000, 1'b0));
        send_event(poll_event(34, 40, 1'b1, 0, 3000, 1'b0));
        send_event(poll_event(255, 40, 1'b1, 0, 3000, 1'b0));
        send_event(poll_event(40, 40, 1'b0, 0, 3000, 1'b0));
        send_event(poll_event(0, 0, 1'b1, 4095, 3000, 1'b0));
    endtask

    task automatic test_relay_and_buzzer();
        send_event(poll_event(20, 40, 1'b1, 0, 0, 1'b1));
        send_event(poll_event(20, 40, 1'b1, 0, 999, 1'b0));
        send_event(poll_event(20, 40, 1'b1, 1500, 4095, 1'b0));
        send_event(poll_event(20, 80, 1'b1, 1500, 0, 1'b1));
        send_event(poll_event(45, 40, 1'b1, 0, 0, 1'b1));
        send_event(poll_event(255, 127, 1'b0, 2499, 0, 1'b1));
        send_event(poll_event(20, 127, 1'b1, 0, 1000, 1'b1));
    endtask

    task automatic test_override_and_commands();
        send_event(cmd_event(ACT_SELECT));
        send_event(poll_event(20, 40, 1'b1, 0, 4095, 1'b0));
        send_event(cmd_event(ACT_SELECT));
        send_event(cmd_event(ACT_SELECT));
        send_event(cmd_event(ACT_RLY_ON));
        send_event(poll_event(50, 40, 1'b1, 4095, 4095, 1'b0));
        send_event(cmd_event(ACT_RLY_OFF));
        send_event(cmd_event(ACT_FAN_OFF));
        send_event(cmd_event(ACT_AUTO));
        send_event(cmd_event(ACT_FAN_MAX));
    endtask

    task automatic test_threshold_extremes();
        wait_idle();
        foreach (thr[i]) program_register(t_cfg_idx'(i), '0);
        send_event(poll_event(0, 0, 1'b1, 0, 0, 1'b1));
        send_event(cmd_event(ACT_FAN_MAX));
        send_event(poll_event(255, 127, 1'b0, 4095, 4095, 1'b1));
        wait_idle();
        foreach (thr[i]) program_register(t_cfg_idx'(i), 12'hFFF);
        send_event(poll_event(254, 126, 1'b1, 4094, 4094, 1'b1));
        send_event(poll_event(255, 127, 1'b1, 4095, 0, 1'b0));
        send_event(cmd_event(ACT_FAN_MAX));
        wait_idle();
        program_register(CFG_TEMP_WARN, 12'd40);
        program_register(CFG_TEMP_HIGH, 12'd40);
        send_event(poll_event(39, 40, 1'b1, 0, 0, 1'b0));
        send_event(poll_event(40, 40, 1'b1, 0, 0, 1'b0));
        wait_idle();
        program_register(CFG_TEMP_WARN, 12'd50);
        program_register(CFG_TEMP_HIGH, 12'd20);
        send_event(poll_event(30, 40, 1'b1, 0, 0, 1'b0));
        send_event(poll_event(50, 40, 1'b1, 0, 0, 1'b0));
        wait_idle();
        program_register(CFG_TEMP_WARN, 12'd0);
        program_register(CFG_TEMP_HIGH, 12'd255);
        program_register(CFG_FAN_PERIOD, 12'd4095);
        send_event(poll_event(254, 40, 1'b1, 0, 0, 1'b0));
        send_event(poll_event(1, 40, 1'b1, 0, 0, 1'b0));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            randomize_thresholds(phase == 5);
            no_gaps = (phase == 2);
            repeat (PHASE_EVENTS) send_event(random_event());
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_fan_ramp();
        test_relay_and_buzzer();
        test_override_and_commands();
        test_threshold_extremes();
        test_random_traffic();
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (actuator_q.size() != 0) begin
            log_failure($sformatf("%0d expected transactions never arrived", actuator_q.size()));
        end
        if (fail_count == 0) begin
            $display("tb_sensor_threshold_actuator_control_unit: PASS");
        end else begin
            $display("tb_sensor_threshold_actuator_control_unit: FAIL");
        end
        $finish;
    end

endmodule
